@@ rtl/core/cle_pkg.sv @@
// shared constants and control/status types for the console line editor
package cle_pkg;

    localparam int BUF_DEPTH = 128;
    localparam int SLOT_W    = $clog2(BUF_DEPTH);
    localparam int IDX_W     = SLOT_W + 1;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_EOF  = 8'h04;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_PLST = 8'h10;
    localparam logic [7:0] CH_KILL = 8'h15;
    localparam logic [7:0] CH_DEL  = 8'h7f;

    localparam logic ACT_RX  = 1'b0;
    localparam logic ACT_POP = 1'b1;

    typedef struct packed {
        logic cap_in;
        logic pop_rd;
        logic pop_fin;
        logic do_bs;
        logic do_store;
        logic kill_start;
        logic kill_step;
    } t_cmd;

    typedef struct packed {
        logic is_pop;
        logic is_ignore;
        logic is_kill;
        logic is_bs;
        logic can_pop;
        logic at_commit;
        logic last_kill;
        logic rd_lf;
    } t_sts;

endpackage

@@ rtl/core/cle_ctrl.sv @@
// controller state machine sequencing receive, erase, kill and pop operations
module cle_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  cle_pkg::t_sts i_sts,
    output cle_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_KILL = 5'b00100,
        S_POP  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.is_pop) begin
                    if (i_sts.can_pop) begin
                        o_cmd.pop_rd = 1'b1;
                        n_state      = S_POP;
                    end else begin
                        n_state = S_OUT;
                    end
                end else if (i_sts.is_ignore) begin
                    n_state = S_OUT;
                end else if (i_sts.is_kill) begin
                    o_cmd.kill_start = 1'b1;
                    n_state          = i_sts.at_commit ? S_OUT : S_KILL;
                end else if (i_sts.is_bs) begin
                    o_cmd.do_bs = 1'b1;
                    n_state     = S_OUT;
                end else begin
                    o_cmd.do_store = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_KILL: begin
                // one stored byte checked per cycle, next read issued alongside
                if (i_sts.rd_lf) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.kill_step = 1'b1;
                    if (i_sts.last_kill) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_POP: begin
                o_cmd.pop_fin = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/cle_dp.sv @@
// datapath: ring buffer store, read/commit/edit indices and result registers
module cle_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_action,
    input  logic [7:0]    i_char_in,
    input  cle_pkg::t_cmd i_cmd,
    output cle_pkg::t_sts o_sts,
    output logic          o_echo_valid,
    output logic [7:0]    o_echo_char,
    output logic [7:0]    o_erase_count,
    output logic          o_line_ready,
    output logic          o_read_valid,
    output logic [7:0]    o_read_char
);

    localparam int IW = cle_pkg::IDX_W;
    localparam int SW = cle_pkg::SLOT_W;

    logic [7:0] r_mem [cle_pkg::BUF_DEPTH];
    logic [7:0] r_rdata;

    logic [IW-1:0] r_read_idx;
    logic [IW-1:0] r_commit_idx;
    logic [IW-1:0] r_edit_idx;

    logic       r_action;
    logic [7:0] r_char;

    logic       r_echo_valid;
    logic [7:0] r_echo_char;
    logic [7:0] r_erase_count;
    logic       r_line_ready;
    logic       r_read_valid;
    logic [7:0] r_read_char;

    logic [IW-1:0] w_edit_m1;
    logic [IW-1:0] w_edit_m2;
    logic [IW-1:0] w_edit_p1;
    logic [IW-1:0] w_fill;
    logic [IW-1:0] w_fill_p1;
    logic          w_room;
    logic          w_commit_now;
    logic [7:0]    w_mapped;
    logic          w_rd_en;
    logic [SW-1:0] w_rd_addr;

    assign w_edit_m1 = r_edit_idx - IW'(1);
    assign w_edit_m2 = r_edit_idx - IW'(2);
    assign w_edit_p1 = r_edit_idx + IW'(1);
    assign w_fill    = r_edit_idx - r_read_idx;
    assign w_fill_p1 = w_edit_p1 - r_read_idx;
    // indices run modulo twice the depth, so the top bit flags a full buffer
    assign w_room    = !w_fill[IW-1];
    assign w_mapped  = (r_char == cle_pkg::CH_CR) ? cle_pkg::CH_LF : r_char;
    assign w_commit_now = (w_mapped == cle_pkg::CH_LF) || (w_mapped == cle_pkg::CH_EOF) ||
                          (w_fill_p1 == IW'(cle_pkg::BUF_DEPTH));

    assign o_sts.is_pop    = (r_action == cle_pkg::ACT_POP);
    assign o_sts.is_ignore = (r_char == cle_pkg::CH_NUL) || (r_char == cle_pkg::CH_PLST);
    assign o_sts.is_kill   = (r_char == cle_pkg::CH_KILL);
    assign o_sts.is_bs     = (r_char == cle_pkg::CH_BS) || (r_char == cle_pkg::CH_DEL);
    assign o_sts.can_pop   = (r_read_idx != r_commit_idx);
    assign o_sts.at_commit = (r_edit_idx == r_commit_idx);
    assign o_sts.last_kill = (w_edit_m1 == r_commit_idx);
    assign o_sts.rd_lf     = (r_rdata == cle_pkg::CH_LF);

    // read port address: pop reads at the read index, kill walks back from edit
    always_comb begin
        w_rd_en   = i_cmd.pop_rd || i_cmd.kill_start || i_cmd.kill_step;
        w_rd_addr = w_edit_m1[SW-1:0];
        if (i_cmd.pop_rd) begin
            w_rd_addr = r_read_idx[SW-1:0];
        end else if (i_cmd.kill_step) begin
            w_rd_addr = w_edit_m2[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
        if (i_cmd.do_store && w_room) begin
            r_mem[r_edit_idx[SW-1:0]] <= w_mapped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_idx   <= '0;
            r_commit_idx <= '0;
            r_edit_idx   <= '0;
        end else begin
            if (i_cmd.pop_fin) begin
                r_read_idx <= r_read_idx + IW'(1);
            end
            if (i_cmd.do_bs && !o_sts.at_commit) begin
                r_edit_idx <= w_edit_m1;
            end
            if (i_cmd.kill_step) begin
                r_edit_idx <= w_edit_m1;
            end
            if (i_cmd.do_store && w_room) begin
                r_edit_idx <= w_edit_p1;
                if (w_commit_now) begin
                    r_commit_idx <= w_edit_p1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_action      <= i_action;
            r_char        <= i_char_in;
            r_echo_valid  <= 1'b0;
            r_echo_char   <= '0;
            r_erase_count <= '0;
            r_line_ready  <= 1'b0;
            r_read_valid  <= 1'b0;
            r_read_char   <= '0;
        end
        if (i_cmd.pop_fin) begin
            r_read_valid <= 1'b1;
            r_read_char  <= r_rdata;
        end
        if (i_cmd.do_bs && !o_sts.at_commit) begin
            r_erase_count <= 8'd1;
        end
        if (i_cmd.kill_step && (r_erase_count != 8'hff)) begin
            r_erase_count <= r_erase_count + 8'd1;
        end
        if (i_cmd.do_store && w_room) begin
            r_echo_valid <= 1'b1;
            r_echo_char  <= w_mapped;
            r_line_ready <= w_commit_now;
        end
    end

    assign o_echo_valid  = r_echo_valid;
    assign o_echo_char   = r_echo_char;
    assign o_erase_count = r_erase_count;
    assign o_line_ready  = r_line_ready;
    assign o_read_valid  = r_read_valid;
    assign o_read_char   = r_read_char;

endmodule

@@ rtl/core/console_line_editor.sv @@
// console line editor top level: controller plus ring buffer datapath
// sequence: after the input transfer the controller passes an execute state, then shows the
// result for receive, erase and ignored bytes; a pop adds a read state, and kill line checks
// one stored byte per cycle, paced by the single store read port
// throughput: one item in flight, next input
// transfer the cycle after the result transfer; reset: synchronous active low, clears
// indices and controller, store left unset
module console_line_editor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_action,
    input  logic [7:0] i_char_in,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_echo_valid,
    output logic [7:0] o_echo_char,
    output logic [7:0] o_erase_count,
    output logic       o_line_ready,
    output logic       o_read_valid,
    output logic [7:0] o_read_char
);

    cle_pkg::t_cmd w_cmd;
    cle_pkg::t_sts w_sts;

    cle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    cle_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_action      (i_action),
        .i_char_in     (i_char_in),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_echo_valid  (o_echo_valid),
        .o_echo_char   (o_echo_char),
        .o_erase_count (o_erase_count),
        .o_line_ready  (o_line_ready),
        .o_read_valid  (o_read_valid),
        .o_read_char   (o_read_char)
    );

endmodule

@@ rtl/core/cle_checker.sv @@
// port-level checker for the console line editor, bound to the top level
module cle_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_echo_valid,
    input logic [7:0] o_erase_count,
    input logic       o_line_ready,
    input logic       o_read_valid
);

    // one item in flight: never ready for input while a result is shown
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input ready while result pending");

    // a result never appears in the cycle right after an input transfer
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_valid)
        else $error("result shown too early");

    // a pop result carries no echo, erase or commit
    a_pop_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_read_valid) |->
            (!o_echo_valid && !o_line_ready && (o_erase_count == 8'd0)))
        else $error("pop result mixed with edit result");

    // commit only follows a stored and echoed byte
    a_commit_on_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_line_ready) |-> (o_echo_valid && (o_erase_count == 8'd0)))
        else $error("line ready without stored byte");

    // result stays until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("result dropped before transfer");

endmodule

bind console_line_editor cle_checker u_cle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_echo_valid  (o_echo_valid),
    .o_erase_count (o_erase_count),
    .o_line_ready  (o_line_ready),
    .o_read_valid  (o_read_valid)
);
